/* rtl/rpu_pkg.sv */
// Shared types and constants of the RMSprop parameter update block.
// No dependencies; every other file of the block but rpu_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package rpu_pkg;
  localparam int NUM_PARAMS = 1024;
  localparam int IDX_W      = 10;
  localparam int PARAM_W    = 32;
  localparam int AVG_W      = 48;
  localparam int GSUM_W     = 40;
  localparam int RATE_W     = 16;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 25;
  localparam int ROOT_W     = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_ACC    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // command kinds after classification
  localparam logic [1:0] CMD_ACC  = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FROZEN     = 1'd1;

  localparam logic [RATE_W-1:0]    LEARN_RATE_RESET = 16'd655;
  localparam logic [DIV_DEN_W-1:0] EPS_Q16          = 25'd7;
  localparam logic [3:0]           AVG_DIVISOR      = 4'd10;
  // ceil(2^23 / 10): exact quotient by ten for 20-bit dividends
  localparam logic [19:0]          DIV10_RECIP      = 20'd838861;

  typedef struct packed {
    logic [1:0]                op;
    logic [IDX_W-1:0]          index;
    logic signed [PARAM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic signed [PARAM_W-1:0] param_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [IDX_W-1:0]          index;
    logic signed [PARAM_W-1:0] value;
  } cmd_t;

  // queue head handed from front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;
endpackage
`default_nettype wire

/* rtl/rmsprop_param_update.sv */
// Accumulate and load are written in the back end's read state, a read result goes to the
// output register from the output state, and an update result after a 4-step divide by ten,
// a bit-serial root and a bit-serial divider pass. The back end runs one item at a time and
// holds in its output state while the result register is full; a two-entry queue takes items
// meanwhile. Reset (synchronous, active high) starts a clearing pass over the average and
// accumulator RAMs; full stays high until it ends. Registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module rmsprop_param_update import rpu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              in_item,
  output logic                       empty,
  input  wire logic                  pop,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  logic [RATE_W-1:0] learn_rate;
  logic              frozen;
  head_t             head;
  logic              head_pop;
  logic              clearing;
  logic              res_load;
  out_item_t         res;
  logic              out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RESET;
      frozen     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE: learn_rate <= cfg_data[RATE_W-1:0];
        REG_FROZEN:     frozen     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify, queue for the back end
  rpu_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .frozen(frozen), .hold(clearing), .head(head), .head_pop(head_pop)
  );

  // back: RAM read-modify-write and the update arithmetic
  rpu_back u_back (
    .clk(clk), .rst(rst), .learn_rate(learn_rate), .head(head),
    .head_pop(head_pop), .clearing(clearing), .out_free(!out_valid),
    .res_load(res_load), .res(res)
  );

  // result register: hold the item until popped
  assign empty = !out_valid;
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item <= res;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/rpu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/rpu_front.sv */
// Front end: accepts input items, classifies them into commands, queues two.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpu_front import rpu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  input  wire logic     frozen,
  input  wire logic     hold,
  output head_t         head,
  input  wire logic     head_pop
);
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       cmd_in;

  assign full   = hold || (count == 2'd2);
  assign accept = push && !full;

  always_comb begin
    cmd_in.index = in_item.index;
    cmd_in.value = in_item.value;
    case (in_item.op)
      OP_ACC:    cmd_in.kind = CMD_ACC;
      OP_UPDATE: cmd_in.kind = frozen ? CMD_READ : CMD_STEP;
      OP_LOAD:   cmd_in.kind = CMD_LOAD;
      default:   cmd_in.kind = CMD_READ;
    endcase
  end

  assign head = {(count != 2'd0), q[rd_ptr]};

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (head_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(head_pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/rpu_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpu_div import rpu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      busy,
  output logic      [DIV_NUM_W-1:0] quo
);
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [6:0]           cnt;

  assign rem_sh = {rem[DIV_DEN_W-1:0], quo[DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem <= rem_sh - {1'b0, den_r};
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'(DIV_NUM_W);
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/rpu_sqrt.sv */
// Integer square root, one result bit per cycle.
// Depends on rpu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpu_sqrt import rpu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AVG_W-1:0] x,
  output logic                  busy,
  output logic      [ROOT_W-1:0] root
);
  logic [AVG_W-1:0] rem;
  logic [AVG_W-1:0] res;
  logic [AVG_W-1:0] bitv;
  logic [AVG_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= x;
      res  <= '0;
      bitv <= AVG_W'(1) << (AVG_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv[0]) begin
      busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/rpu_back.sv */
// Back end: owns the parameter, average and accumulator RAMs and runs commands.
// Depends on rpu_pkg, rpu_ram, rpu_div and rpu_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module rpu_back import rpu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [RATE_W-1:0] learn_rate,
  input  wire head_t             head,
  output logic                   head_pop,
  output logic                   clearing,
  input  wire logic              out_free,
  output logic                   res_load,
  output out_item_t              res
);
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_MUL      = 4'd3;
  localparam logic [3:0] S_AVG_GO   = 4'd4;
  localparam logic [3:0] S_AVG_DIV  = 4'd5;
  localparam logic [3:0] S_SQRT     = 4'd6;
  localparam logic [3:0] S_STEP_DIV = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]                state;
  logic [IDX_W-1:0]          clr_cnt;
  cmd_t                      cur;
  logic signed [PARAM_W-1:0] p_r;
  logic                      g_neg;
  logic [GSUM_W-1:0]         mag_r;
  logic [AVG_W-1:0]          avg_r;
  logic [63:0]               sq_r;
  logic [55:0]               prod_r;

  logic [PARAM_W-1:0] p_rd;
  logic [AVG_W-1:0]   avg_rd;
  logic [GSUM_W-1:0]  gsum_rd;

  logic               p_we, avg_we, gsum_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [PARAM_W-1:0] p_wd;
  logic [AVG_W-1:0]   avg_wd;
  logic [GSUM_W-1:0]  gsum_wd;

  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 sqrt_start, sqrt_busy;
  logic [ROOT_W-1:0]    root;

  logic [DIV_NUM_W-1:0] d10_num;
  logic [DIV_NUM_W-1:0] d10_quo;
  logic [3:0]           d10_rem;
  logic [2:0]           d10_cnt;
  logic [19:0]          d10_x;
  logic [39:0]          d10_prod;
  logic [15:0]          d10_q;
  logic [3:0]           d10_r;
  logic                 d10_done;

  logic signed [GSUM_W:0]   gsum_add;
  logic [GSUM_W-1:0]        gsum_sat;
  logic [AVG_W-1:0]         avg_new;
  logic signed [57:0]       p_diff;
  logic signed [PARAM_W-1:0] p_new;

  rpu_ram #(.WIDTH(PARAM_W), .DEPTH(NUM_PARAMS)) u_param_ram (
    .clk(clk), .we(p_we), .wr_addr(wr_addr), .wr_data(p_wd),
    .rd_addr(head.cmd.index), .rd_data(p_rd)
  );
  rpu_ram #(.WIDTH(AVG_W), .DEPTH(NUM_PARAMS)) u_avg_ram (
    .clk(clk), .we(avg_we), .wr_addr(wr_addr), .wr_data(avg_wd),
    .rd_addr(head.cmd.index), .rd_data(avg_rd)
  );
  rpu_ram #(.WIDTH(GSUM_W), .DEPTH(NUM_PARAMS)) u_gsum_ram (
    .clk(clk), .we(gsum_we), .wr_addr(wr_addr), .wr_data(gsum_wd),
    .rd_addr(head.cmd.index), .rd_data(gsum_rd)
  );

  rpu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );
  rpu_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(avg_new),
    .busy(sqrt_busy), .root(root)
  );

  // saturating accumulate
  assign gsum_add = {gsum_rd[GSUM_W-1], gsum_rd} + (GSUM_W+1)'(cur.value);
  always_comb begin
    if (gsum_add[GSUM_W] != gsum_add[GSUM_W-1]) begin
      gsum_sat = gsum_add[GSUM_W] ? {1'b1, {(GSUM_W-1){1'b0}}} : {1'b0, {(GSUM_W-1){1'b1}}};
    end else begin
      gsum_sat = gsum_add[GSUM_W-1:0];
    end
  end

  // divide by ten: 16 dividend bits per step, quotient digit by reciprocal multiply
  assign d10_x    = {d10_rem, d10_num[DIV_NUM_W-1:DIV_NUM_W-16]};
  assign d10_prod = 40'(d10_x) * 40'(DIV10_RECIP);
  assign d10_q    = d10_prod[38:23];
  assign d10_r    = 4'(d10_x - 20'(d10_q) * 20'(AVG_DIVISOR));
  assign d10_done = (d10_cnt == 3'd4);

  assign avg_new = (d10_quo[DIV_NUM_W-1:AVG_W] != '0) ? {AVG_W{1'b1}} : d10_quo[AVG_W-1:0];

  // signed step applied to the parameter, saturated to 32 bits
  always_comb begin
    if (g_neg) begin
      p_diff = 58'(p_r) + $signed({2'b00, div_quo[55:0]});
    end else begin
      p_diff = 58'(p_r) - $signed({2'b00, div_quo[55:0]});
    end
    if (p_diff > 58'sd2147483647) begin
      p_new = 32'sh7fffffff;
    end else if (p_diff < -58'sd2147483648) begin
      p_new = 32'sh80000000;
    end else begin
      p_new = p_diff[PARAM_W-1:0];
    end
  end

  assign clearing = (state == S_CLEAR);
  assign head_pop = (state == S_IDLE) && head.valid;
  assign res_load = (state == S_OUT) && out_free;
  assign res      = {cur.index, p_r};

  always_comb begin
    p_we       = 1'b0;
    avg_we     = 1'b0;
    gsum_we    = 1'b0;
    wr_addr    = cur.index;
    p_wd       = cur.value;
    avg_wd     = '0;
    gsum_wd    = '0;
    div_start  = 1'b0;
    div_num    = {8'd0, prod_r};
    div_den    = 25'(root) + EPS_Q16;
    sqrt_start = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_addr = clr_cnt;
        avg_we  = 1'b1;
        gsum_we = 1'b1;
      end
      S_READ: begin
        if (cur.kind == CMD_ACC) begin
          gsum_we = 1'b1;
          gsum_wd = gsum_sat;
        end else if (cur.kind == CMD_LOAD) begin
          p_we    = 1'b1;
          avg_we  = 1'b1;
          gsum_we = 1'b1;
        end
      end
      S_AVG_DIV: begin
        if (d10_done) begin
          avg_we     = 1'b1;
          avg_wd     = avg_new;
          sqrt_start = 1'b1;
        end
      end
      S_SQRT: begin
        div_start = !sqrt_busy;
      end
      S_STEP_DIV: begin
        if (!div_busy) begin
          p_we    = 1'b1;
          p_wd    = p_new;
          gsum_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur <= head.cmd;
    end
    case (state)
      S_READ: begin
        p_r   <= p_rd;
        g_neg <= gsum_rd[GSUM_W-1];
        mag_r <= gsum_rd[GSUM_W-1] ? (~gsum_rd + GSUM_W'(1)) : gsum_rd;
        avg_r <= avg_rd;
      end
      S_MUL: begin
        sq_r   <= 64'(mag_r[GSUM_W-1:8]) * 64'(mag_r[GSUM_W-1:8]);
        prod_r <= 56'(learn_rate) * 56'(mag_r);
      end
      S_AVG_GO: begin
        d10_num <= 64'({avg_r, 3'b000}) + 64'(avg_r) + sq_r;
        d10_quo <= '0;
        d10_rem <= '0;
        d10_cnt <= '0;
      end
      S_AVG_DIV: begin
        if (!d10_done) begin
          d10_num <= {d10_num[DIV_NUM_W-17:0], 16'd0};
          d10_quo <= {d10_quo[DIV_NUM_W-17:0], d10_q};
          d10_rem <= d10_r;
          d10_cnt <= d10_cnt + 3'd1;
        end
      end
      S_STEP_DIV: begin
        if (!div_busy) begin
          p_r <= p_new;
        end
      end
      default: begin
      end
    endcase

    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == IDX_W'(NUM_PARAMS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (cur.kind == CMD_STEP) begin
            state <= S_MUL;
          end else if (cur.kind == CMD_READ) begin
            state <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL:    state <= S_AVG_GO;
        S_AVG_GO: state <= S_AVG_DIV;
        S_AVG_DIV: begin
          if (d10_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!sqrt_busy) begin
            state <= S_STEP_DIV;
          end
        end
        S_STEP_DIV: begin
          if (!div_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
